[hw/rtl/atapio_pkg.sv]
package atapio_pkg;

  localparam int WORDS_PER_SECTOR = 256;
  localparam int WI_W             = $clog2(WORDS_PER_SECTOR);
  localparam int LBA_W            = 28;
  localparam int CNT_W            = 9;
  localparam int LIM_W            = 20;
  localparam int CFG_DATA_W       = 20;
  localparam int CFG_IDX_W        = 3;

  // item modes
  localparam logic [2:0] MODE_START_RD = 3'd0;
  localparam logic [2:0] MODE_START_WR = 3'd1;
  localparam logic [2:0] MODE_RESP     = 3'd2;
  localparam logic [2:0] MODE_TICK     = 3'd3;
  localparam logic [2:0] MODE_WORD     = 3'd4;

  // bus operations
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_REG_RD  = 3'd1;
  localparam logic [2:0] OP_REG_WR  = 3'd2;
  localparam logic [2:0] OP_DATA_RD = 3'd3;
  localparam logic [2:0] OP_DATA_WR = 3'd4;

  // task file registers
  localparam logic [2:0] TF_DATA    = 3'd0;
  localparam logic [2:0] TF_NSECT   = 3'd2;
  localparam logic [2:0] TF_SECNUM  = 3'd3;
  localparam logic [2:0] TF_CYLLO   = 3'd4;
  localparam logic [2:0] TF_CYLHI   = 3'd5;
  localparam logic [2:0] TF_DEVHEAD = 3'd6;
  localparam logic [2:0] TF_CMDSTAT = 3'd7;

  localparam logic [7:0] CMD_READ_SECTORS  = 8'h20;
  localparam logic [7:0] CMD_WRITE_SECTORS = 8'h30;
  localparam logic [7:0] CMD_INIT_PARAMS   = 8'h91;
  localparam logic [7:0] DEVCTL_SRST       = 8'h04;
  localparam logic [7:0] DEV_MASTER        = 8'hA0;
  localparam logic [7:0] DEV_SLAVE         = 8'hB0;
  localparam logic [7:0] DEV_LBA           = 8'h40;

  // outcomes
  localparam logic [2:0] OUT_OK       = 3'd0;
  localparam logic [2:0] OUT_ZERO_CNT = 3'd1;
  localparam logic [2:0] OUT_NOT_RDY  = 3'd2;
  localparam logic [2:0] OUT_DEV_ERR  = 3'd3;
  localparam logic [2:0] OUT_TIMEOUT  = 3'd4;

  // config register indexes
  localparam logic [2:0] REG_USE_LBA   = 3'd0;
  localparam logic [2:0] REG_SPT       = 3'd1;
  localparam logic [2:0] REG_HEADS     = 3'd2;
  localparam logic [2:0] REG_SLAVE     = 3'd3;
  localparam logic [2:0] REG_INTRQ_EN  = 3'd4;
  localparam logic [2:0] REG_RDY_TO    = 3'd5;
  localparam logic [2:0] REG_DRQ_LIM   = 3'd6;
  localparam logic [2:0] REG_REC_TO    = 3'd7;

  typedef enum logic [3:0] {
    K_RD_STATUS, K_DATA_RD, K_DATA_WR, K_WORD,
    K_TF_COUNT, K_TF_SEC, K_TF_CYLLO, K_TF_CYLHI, K_TF_DEV, K_TF_CMD,
    K_SRST_ON, K_SRST_OFF, K_GEO_DEV, K_GEO_SPT, K_GEO_CMD, K_DONE
  } kind_t;

  typedef enum logic [1:0] {LIM_READY, LIM_DRQ, LIM_REC} lim_sel_t;

  typedef struct packed {
    logic     emit;
    kind_t    kind;
    logic     last;
    logic [2:0] outc;
    logic     start;
    logic     poll_clr;
    logic     poll_inc;
    lim_sel_t lim_sel;
    logic     wi_clr;
    logic     wi_inc;
    logic     sec_end;
    logic     done_clr;
    logic     chs_start;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic count_bad;
    logic is_write;
    logic use_lba;
    logic intrq_en;
    logic irq;
    logic st_bsy;
    logic st_drdy;
    logic st_drq;
    logic st_err;
    logic wi_last;
    logic left_one;
    logic done_zero;
    logic poll_expired;
    logic chs_done;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/ata_pio_sector_transfer_unit.sv]
// ATA PIO host sector sequencer (LBA28 or CHS addressing).
// Input channel (in_valid/in_ready): one beat is a start read/write, a bus
// read response (status or data word), a poll tick, or a host write word.
// Output channel (out_valid/out_ready): each beat is one bus request
// (register read/write, data read/write), a delivered sector word, or a
// completion with outcome and byte count; last marks the final beat of the
// results caused by one input beat. An input beat may cause no result.
// Config: cfg_we/cfg_index/cfg_data, write-only, to be written while idle.
// Timing: an input beat is taken only when the sequencer is idle; it is decoded,
// then its results are produced in turn, and the next beat is taken once the
// sequencer has returned to idle. Starting a CHS command runs two 28-step
// divisions, once per command.
// Results leave through a single output register; while the receiver stalls,
// the sequencer holds its next result, but once idle it can take a new input beat.
// Reset (rst, synchronous) returns to idle, loads the default geometry and
// timeout registers and drops out_valid.
module ata_pio_sector_transfer_unit import atapio_pkg::*; #(
  parameter int POLL_COUNTER_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            mode,
  input  logic [LBA_W-1:0]      lba,
  input  logic [CNT_W-1:0]      sector_count,
  input  logic [15:0]           bus_read_value,
  input  logic [15:0]           write_word,
  input  logic                  intrq_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            bus_op,
  output logic [2:0]            bus_register,
  output logic                  control_block,
  output logic [15:0]           bus_write_value,
  output logic [15:0]           read_data,
  output logic                  read_data_valid,
  output logic                  done_res,
  output logic [2:0]            outcome,
  output logic [17:0]           byte_count,
  output logic                  last
);
  cmd_t cmd;
  sts_t sts;
  logic in_fire;

  assign in_fire = in_valid && in_ready;

  // sequencer: command phases, poll outcomes, recovery flow
  atapio_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  // config, counters, CHS divider and the output register
  atapio_dp #(.POLL_COUNTER_BITS(POLL_COUNTER_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_fire(in_fire), .mode(mode), .lba(lba), .sector_count(sector_count),
    .bus_read_value(bus_read_value), .write_word(write_word),
    .intrq_level(intrq_level),
    .cmd(cmd), .sts(sts),
    .out_ready(out_ready), .out_valid(out_valid),
    .bus_op(bus_op), .bus_register(bus_register), .control_block(control_block),
    .bus_write_value(bus_write_value), .read_data(read_data),
    .read_data_valid(read_data_valid), .done_res(done_res), .outcome(outcome),
    .byte_count(byte_count), .last(last)
  );

  // never load the output register over a waiting beat
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free) else $error("result overwrote a pending beat");

  // nothing is produced while waiting for input
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.emit) else $error("result emitted while idle");

  // a completion always closes the item's results
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> last) else $error("completion without last");

  // a delivered word carries no bus request
  a_word_no_bus: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_data_valid |-> bus_op == OP_NONE && !done_res)
    else $error("data word mixed with bus request");
endmodule

[hw/rtl/atapio_div.sv]
// restoring divider, one quotient bit per cycle
module atapio_div import atapio_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [LBA_W-1:0] dividend,
  input  logic [7:0]       divisor,
  output logic             done,
  output logic [LBA_W-1:0] quot,
  output logic [7:0]       rem
);
  localparam int CW = $clog2(LBA_W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [7:0]    dvs;
  logic [8:0]    trial;
  logic [8:0]    diff;
  logic          ge;

  assign trial = {rem, quot[LBA_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
      cnt  <= CW'(LBA_W - 1);
      busy <= 1'b1;
    end else if (busy) begin
      rem  <= ge ? diff[7:0] : trial[7:0];
      quot <= {quot[LBA_W-2:0], ge};
      cnt  <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

[hw/rtl/atapio_dp.sv]
module atapio_dp import atapio_pkg::*; #(
  parameter int POLL_COUNTER_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_fire,
  input  logic [2:0]            mode,
  input  logic [LBA_W-1:0]      lba,
  input  logic [CNT_W-1:0]      sector_count,
  input  logic [15:0]           bus_read_value,
  input  logic [15:0]           write_word,
  input  logic                  intrq_level,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [2:0]            bus_op,
  output logic [2:0]            bus_register,
  output logic                  control_block,
  output logic [15:0]           bus_write_value,
  output logic [15:0]           read_data,
  output logic                  read_data_valid,
  output logic                  done_res,
  output logic [2:0]            outcome,
  output logic [17:0]           byte_count,
  output logic                  last
);
  localparam int PW = POLL_COUNTER_BITS;
  localparam int XW = (PW > LIM_W) ? PW : LIM_W;
  localparam logic [PW-1:0] PC_MAX = '1;

  // configuration
  logic              use_lba, device_slave, intrq_enabled;
  logic [7:0]        spt;
  logic [4:0]        heads;
  logic [LIM_W-1:0]  rdy_to, drq_lim, rec_to;

  // item latches
  logic [2:0]        mode_q;
  logic [LBA_W-1:0]  lba_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [15:0]       resp_q, wword_q;
  logic              irq_q;

  logic              is_write;
  logic [LBA_W-1:0]  saved_lba;
  logic [CNT_W-1:0]  saved_count, sectors_left, sectors_done;
  logic [WI_W-1:0]   word_index;
  logic [PW-1:0]     poll_count, poll_inc;
  logic [LIM_W-1:0]  limit;

  // CHS translation
  logic              chs_stage, chs_done;
  logic [7:0]        chs_sect;
  logic [15:0]       chs_cyl;
  logic [3:0]        chs_head;
  logic              div_start, div_done;
  logic [LBA_W-1:0]  div_dividend, div_quot;
  logic [7:0]        div_divisor, div_rem, spt_eff;
  logic [4:0]        heads_eff;
  logic              count_bad;
  logic [7:0]        dev;

  assign spt_eff   = (spt == '0) ? 8'd1 : spt;
  assign heads_eff = (heads == '0) ? 5'd1 : heads;
  assign div_start = cmd.chs_start || (div_done && !chs_stage);
  assign div_dividend = cmd.chs_start ? saved_lba : div_quot;
  assign div_divisor  = cmd.chs_start ? spt_eff : {3'b000, heads_eff};
  assign count_bad = (cnt_q == '0) || (cnt_q > CNT_W'(256));
  assign dev = device_slave ? DEV_SLAVE : DEV_MASTER;

  atapio_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quot(div_quot), .rem(div_rem)
  );

  always_comb begin
    case (cmd.lim_sel)
      LIM_READY: limit = rdy_to;
      LIM_DRQ:   limit = drq_lim;
      default:   limit = rec_to;
    endcase
  end

  assign poll_inc = (poll_count == PC_MAX) ? poll_count : poll_count + 1'b1;

  always_comb begin
    sts.mode         = mode_q;
    sts.count_bad    = count_bad;
    sts.is_write     = is_write;
    sts.use_lba      = use_lba;
    sts.intrq_en     = intrq_enabled;
    sts.irq          = irq_q;
    sts.st_bsy       = resp_q[7];
    sts.st_drdy      = resp_q[6];
    sts.st_drq       = resp_q[3];
    sts.st_err       = resp_q[0];
    sts.wi_last      = word_index == WI_W'(WORDS_PER_SECTOR - 1);
    sts.left_one     = sectors_left == CNT_W'(1);
    sts.done_zero    = sectors_done == '0;
    sts.poll_expired = (XW'(poll_inc) >= XW'(limit)) || (poll_inc == PC_MAX);
    sts.chs_done     = chs_done;
    sts.out_free     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_lba       <= 1'b1;
      spt           <= 8'd63;
      heads         <= 5'd16;
      device_slave  <= 1'b0;
      intrq_enabled <= 1'b0;
      rdy_to        <= LIM_W'(500000);
      drq_lim       <= LIM_W'(100000);
      rec_to        <= LIM_W'(200000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_USE_LBA:  use_lba       <= cfg_data[0];
        REG_SPT:      spt           <= cfg_data[7:0];
        REG_HEADS:    heads         <= cfg_data[4:0];
        REG_SLAVE:    device_slave  <= cfg_data[0];
        REG_INTRQ_EN: intrq_enabled <= cfg_data[0];
        REG_RDY_TO:   rdy_to        <= cfg_data[LIM_W-1:0];
        REG_DRQ_LIM:  drq_lim       <= cfg_data[LIM_W-1:0];
        default:      rec_to        <= cfg_data[LIM_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_q  <= mode;
      lba_q   <= lba;
      cnt_q   <= sector_count;
      resp_q  <= bus_read_value;
      wword_q <= write_word;
      irq_q   <= intrq_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_write     <= 1'b0;
      saved_lba    <= '0;
      saved_count  <= '0;
      sectors_left <= '0;
      sectors_done <= '0;
      word_index   <= '0;
      poll_count   <= '0;
      chs_stage    <= 1'b0;
      chs_done     <= 1'b0;
    end else begin
      chs_done <= 1'b0;
      if (cmd.start) begin
        is_write     <= mode_q[0];
        saved_lba    <= lba_q;
        saved_count  <= count_bad ? '0 : cnt_q;
        sectors_left <= cnt_q;
        sectors_done <= '0;
        poll_count   <= '0;
      end
      if (cmd.poll_clr) poll_count <= '0;
      else if (cmd.poll_inc) poll_count <= poll_inc;
      if (cmd.wi_clr) word_index <= '0;
      else if (cmd.wi_inc) word_index <= word_index + 1'b1;
      if (cmd.sec_end) begin
        sectors_left <= sectors_left - 1'b1;
        sectors_done <= sectors_done + 1'b1;
      end else if (cmd.done_clr) begin
        sectors_done <= '0;
      end
      if (cmd.chs_start) chs_stage <= 1'b0;
      else if (div_done) begin
        if (!chs_stage) begin
          chs_sect  <= div_rem + 1'b1;
          chs_stage <= 1'b1;
        end else begin
          chs_cyl   <= div_quot[15:0];
          chs_head  <= div_rem[3:0];
          chs_stage <= 1'b0;
          chs_done  <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      bus_op          <= OP_NONE;
      bus_register    <= TF_DATA;
      control_block   <= 1'b0;
      bus_write_value <= '0;
      read_data       <= '0;
      read_data_valid <= 1'b0;
      done_res        <= 1'b0;
      outcome         <= OUT_OK;
      byte_count      <= '0;
      last            <= cmd.last;
      unique case (cmd.kind)
        K_RD_STATUS: begin
          bus_op       <= OP_REG_RD;
          bus_register <= TF_CMDSTAT;
        end
        K_DATA_RD: bus_op <= OP_DATA_RD;
        K_DATA_WR: begin
          bus_op          <= OP_DATA_WR;
          bus_write_value <= wword_q;
        end
        K_WORD: begin
          read_data       <= resp_q;
          read_data_valid <= 1'b1;
        end
        K_TF_COUNT: begin
          bus_op          <= OP_REG_WR;
          bus_register    <= TF_NSECT;
          bus_write_value <= {8'h00, saved_count[7:0]};
        end
        K_TF_SEC: begin
          bus_op          <= OP_REG_WR;
          bus_register    <= TF_SECNUM;
          bus_write_value <= {8'h00, use_lba ? saved_lba[7:0] : chs_sect};
        end
        K_TF_CYLLO: begin
          bus_op          <= OP_REG_WR;
          bus_register    <= TF_CYLLO;
          bus_write_value <= {8'h00, use_lba ? saved_lba[15:8] : chs_cyl[7:0]};
        end
        K_TF_CYLHI: begin
          bus_op          <= OP_REG_WR;
          bus_register    <= TF_CYLHI;
          bus_write_value <= {8'h00, use_lba ? saved_lba[23:16] : chs_cyl[15:8]};
        end
        K_TF_DEV: begin
          bus_op          <= OP_REG_WR;
          bus_register    <= TF_DEVHEAD;
          bus_write_value <= {8'h00, use_lba ? (dev | DEV_LBA | {4'h0, saved_lba[27:24]})
                                             : (dev | {4'h0, chs_head})};
        end
        K_TF_CMD: begin
          bus_op          <= OP_REG_WR;
          bus_register    <= TF_CMDSTAT;
          bus_write_value <= {8'h00, is_write ? CMD_WRITE_SECTORS : CMD_READ_SECTORS};
        end
        K_SRST_ON: begin
          bus_op          <= OP_REG_WR;
          bus_register    <= TF_DEVHEAD;
          control_block   <= 1'b1;
          bus_write_value <= {8'h00, DEVCTL_SRST};
        end
        K_SRST_OFF: begin
          bus_op        <= OP_REG_WR;
          bus_register  <= TF_DEVHEAD;
          control_block <= 1'b1;
        end
        K_GEO_DEV: begin
          bus_op          <= OP_REG_WR;
          bus_register    <= TF_DEVHEAD;
          bus_write_value <= {8'h00, dev | {4'h0, 4'(heads - 1'b1)}};
        end
        K_GEO_SPT: begin
          bus_op          <= OP_REG_WR;
          bus_register    <= TF_NSECT;
          bus_write_value <= {8'h00, spt};
        end
        K_GEO_CMD: begin
          bus_op          <= OP_REG_WR;
          bus_register    <= TF_CMDSTAT;
          bus_write_value <= {8'h00, CMD_INIT_PARAMS};
        end
        K_DONE: begin
          done_res   <= 1'b1;
          outcome    <= cmd.outc;
          byte_count <= (cmd.outc == OUT_OK) ? {saved_count, 9'b0} : '0;
        end
      endcase
    end
  end
endmodule

[hw/rtl/atapio_ctrl.sv]
module atapio_ctrl import atapio_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_ISSUE, S_CLRRD, S_FINISH, S_WORD, S_DATARD, S_DATAWR,
    S_SECEND, S_STATUS, S_PFAIL, S_AFTER, S_GEO1, S_GEO2, S_GEO3,
    S_SRST1, S_SRST2, S_DIV, S_PROG
  } state_t;

  typedef enum logic [3:0] {
    P_IDLE = 4'd0, P_RDY_RD = 4'd1, P_RDY_TK = 4'd2, P_DRQ_CLR = 4'd3,
    P_DRQ_RD = 4'd4, P_DRQ_TK = 4'd5, P_XFER_RD = 4'd6, P_XFER_WR = 4'd7,
    P_CMT_CLR = 4'd8, P_CMT_RD = 4'd9, P_CMT_TK = 4'd10, P_REC_RD = 4'd11,
    P_REC_TK = 4'd12, P_GEO_RD = 4'd13, P_GEO_TK = 4'd14
  } phase_t;

  state_t     state, state_next;
  phase_t     phase, phase_next, rdph, rdph_next;
  logic [2:0] outc, outc_next, fail, fail_next;
  logic [2:0] pidx, pidx_next;
  logic       rdy, clr;

  assign in_ready = state == S_IDLE;
  assign rdy = !sts.st_bsy && sts.st_drdy;
  // INTRQ clear read: never before the first write sector
  assign clr = ((rdph == P_DRQ_RD && !(sts.is_write && sts.done_zero)) || rdph == P_CMT_RD)
               && sts.intrq_en && sts.irq;

  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    rdph_next  = rdph;
    outc_next  = outc;
    fail_next  = fail;
    pidx_next  = pidx;
    cmd.outc   = outc;
    if (rdph == P_RDY_RD) cmd.lim_sel = LIM_READY;
    else if (rdph == P_DRQ_RD || rdph == P_CMT_RD) cmd.lim_sel = LIM_DRQ;
    else cmd.lim_sel = LIM_REC;

    unique case (state)
      S_IDLE: if (in_fire) state_next = S_DECODE;
      S_DECODE: begin
        state_next = S_IDLE;
        case (sts.mode)
          MODE_START_RD, MODE_START_WR: begin
            if (phase == P_IDLE) begin
              cmd.start = 1'b1;
              if (sts.count_bad) begin
                outc_next  = OUT_ZERO_CNT;
                state_next = S_FINISH;
              end else begin
                fail_next  = OUT_OK;
                rdph_next  = P_RDY_RD;
                state_next = S_ISSUE;
              end
            end
          end
          MODE_RESP: begin
            if (phase == P_DRQ_CLR || phase == P_CMT_CLR) state_next = S_CLRRD;
            else if (phase == P_XFER_RD) state_next = S_WORD;
            else if (phase == P_RDY_RD || phase == P_DRQ_RD || phase == P_CMT_RD ||
                     phase == P_REC_RD || phase == P_GEO_RD) begin
              rdph_next  = phase;
              state_next = S_STATUS;
            end
          end
          MODE_TICK: begin
            if (phase == P_RDY_TK || phase == P_DRQ_TK || phase == P_CMT_TK ||
                phase == P_REC_TK || phase == P_GEO_TK) begin
              rdph_next  = phase_t'(phase - 1'b1);
              state_next = S_ISSUE;
            end
          end
          MODE_WORD: if (phase == P_XFER_WR) state_next = S_DATAWR;
          default: state_next = S_IDLE;
        endcase
      end
      S_ISSUE: if (sts.out_free) begin
        cmd.emit   = 1'b1;
        cmd.kind   = K_RD_STATUS;
        cmd.last   = 1'b1;
        phase_next = clr ? phase_t'(rdph - 1'b1) : rdph;
        state_next = S_IDLE;
      end
      S_CLRRD: if (sts.out_free) begin
        cmd.emit   = 1'b1;
        cmd.kind   = K_RD_STATUS;
        cmd.last   = 1'b1;
        phase_next = phase_t'(phase + 1'b1);
        state_next = S_IDLE;
      end
      S_FINISH: if (sts.out_free) begin
        cmd.emit   = 1'b1;
        cmd.kind   = K_DONE;
        cmd.last   = 1'b1;
        phase_next = P_IDLE;
        state_next = S_IDLE;
      end
      S_WORD: if (sts.out_free) begin
        cmd.emit = 1'b1;
        cmd.kind = K_WORD;
        if (sts.wi_last) state_next = S_SECEND;
        else begin
          cmd.wi_inc = 1'b1;
          state_next = S_DATARD;
        end
      end
      S_DATARD: if (sts.out_free) begin
        cmd.emit   = 1'b1;
        cmd.kind   = K_DATA_RD;
        cmd.last   = 1'b1;
        state_next = S_IDLE;
      end
      S_DATAWR: if (sts.out_free) begin
        cmd.emit = 1'b1;
        cmd.kind = K_DATA_WR;
        if (sts.wi_last) state_next = S_SECEND;
        else begin
          cmd.last   = 1'b1;
          cmd.wi_inc = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SECEND: begin
        cmd.sec_end  = 1'b1;
        cmd.poll_clr = 1'b1;
        if (!sts.left_one) begin
          rdph_next  = P_DRQ_RD;
          state_next = S_ISSUE;
        end else if (sts.is_write) begin
          rdph_next  = P_CMT_RD;
          state_next = S_ISSUE;
        end else begin
          outc_next  = OUT_OK;
          state_next = S_FINISH;
        end
      end
      S_STATUS: begin
        state_next = S_PFAIL;
        case (rdph)
          P_RDY_RD: begin
            if (rdy) begin
              pidx_next = '0;
              if (sts.use_lba) state_next = S_PROG;
              else begin
                cmd.chs_start = 1'b1;
                state_next    = S_DIV;
              end
            end
          end
          P_DRQ_RD: begin
            if (sts.st_err) begin
              fail_next  = OUT_DEV_ERR;
              state_next = S_SRST1;
            end else if (!sts.st_bsy && sts.st_drq) begin
              cmd.wi_clr = 1'b1;
              if (sts.is_write) begin
                phase_next = P_XFER_WR;
                state_next = S_IDLE;
              end else begin
                phase_next = P_XFER_RD;
                state_next = S_DATARD;
              end
            end
          end
          P_CMT_RD: begin
            if (sts.st_err) begin
              fail_next  = OUT_DEV_ERR;
              state_next = S_SRST1;
            end else if (!sts.st_bsy) begin
              outc_next  = OUT_OK;
              state_next = S_FINISH;
            end
          end
          P_REC_RD: if (rdy) state_next = S_AFTER;
          default: begin
            if (rdy) begin
              outc_next  = fail;
              state_next = S_FINISH;
            end
          end
        endcase
      end
      S_PFAIL: begin
        cmd.poll_inc = 1'b1;
        if (sts.poll_expired) begin
          if (rdph == P_RDY_RD) begin
            outc_next  = OUT_NOT_RDY;
            state_next = S_FINISH;
          end else if (rdph == P_REC_RD) state_next = S_AFTER;
          else if (rdph == P_GEO_RD) begin
            outc_next  = fail;
            state_next = S_FINISH;
          end else begin
            fail_next  = OUT_TIMEOUT;
            state_next = S_SRST1;
          end
        end else begin
          phase_next = phase_t'(rdph + 1'b1);
          state_next = S_IDLE;
        end
      end
      S_AFTER: begin
        if (!sts.use_lba) state_next = S_GEO1;
        else begin
          outc_next  = fail;
          state_next = S_FINISH;
        end
      end
      S_GEO1: if (sts.out_free) begin
        cmd.emit   = 1'b1;
        cmd.kind   = K_GEO_DEV;
        state_next = S_GEO2;
      end
      S_GEO2: if (sts.out_free) begin
        cmd.emit   = 1'b1;
        cmd.kind   = K_GEO_SPT;
        state_next = S_GEO3;
      end
      S_GEO3: if (sts.out_free) begin
        cmd.emit     = 1'b1;
        cmd.kind     = K_GEO_CMD;
        cmd.poll_clr = 1'b1;
        rdph_next    = P_GEO_RD;
        state_next   = S_ISSUE;
      end
      S_SRST1: if (sts.out_free) begin
        cmd.emit   = 1'b1;
        cmd.kind   = K_SRST_ON;
        state_next = S_SRST2;
      end
      S_SRST2: if (sts.out_free) begin
        cmd.emit     = 1'b1;
        cmd.kind     = K_SRST_OFF;
        cmd.poll_clr = 1'b1;
        rdph_next    = P_REC_RD;
        state_next   = S_ISSUE;
      end
      S_DIV: if (sts.chs_done) state_next = S_PROG;
      S_PROG: if (sts.out_free) begin
        cmd.emit = 1'b1;
        case (pidx)
          3'd0:    cmd.kind = K_TF_COUNT;
          3'd1:    cmd.kind = K_TF_SEC;
          3'd2:    cmd.kind = K_TF_CYLLO;
          3'd3:    cmd.kind = K_TF_CYLHI;
          3'd4:    cmd.kind = K_TF_DEV;
          default: cmd.kind = K_TF_CMD;
        endcase
        if (pidx == 3'd5) begin
          cmd.poll_clr = 1'b1;
          cmd.done_clr = 1'b1;
          rdph_next    = P_DRQ_RD;
          state_next   = S_ISSUE;
        end else begin
          pidx_next = pidx + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= P_IDLE;
      rdph  <= P_IDLE;
      outc  <= OUT_OK;
      fail  <= OUT_OK;
      pidx  <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      rdph  <= rdph_next;
      outc  <= outc_next;
      fail  <= fail_next;
      pidx  <= pidx_next;
    end
  end
endmodule

[dv/ata_pio_sector_transfer_unit_test.sv]
`timescale 1ns / 100ps

module ata_pio_sector_transfer_unit_test;
  import atapio_pkg::*;

  // sequencer phases, in the order the DUT walks them (read/tick pairs, DRQ and commit led by a clear)
  typedef enum int {
    PH_IDLE, PH_RDY_RD, PH_RDY_TK, PH_DRQ_CLR, PH_DRQ_RD, PH_DRQ_TK,
    PH_XFER_RD, PH_XFER_WR, PH_CMT_CLR, PH_CMT_RD, PH_CMT_TK,
    PH_REC_RD, PH_REC_TK, PH_GEO_RD, PH_GEO_TK
  } seq_ph_t;

  typedef struct {
    logic [2:0]  op;
    logic [2:0]  rsel;
    logic        cb;
    logic [15:0] wval;
    logic [15:0] rdata;
    logic        rvalid;
    logic        done;
    logic [2:0]  outc;
    logic [17:0] bytes;
    logic        last;
  } bus_beat_t;

  // directed rows: chk 0 = use predictor, 1 = typed zero-count completion,
  // 2 = typed "no result"
  typedef struct {
    logic [2:0]  m;
    logic [27:0] a;
    logic [8:0]  n;
    logic [15:0] rv;
    logic [15:0] ww;
    logic        irq;
    int          chk;
  } row_t;

  localparam longint PC_MAX = (64'd1 << 20) - 1;
  localparam int WDOG_LIMIT = 3000;
  localparam int SETTLE = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] mode = MODE_TICK;
  logic [LBA_W-1:0] lba = '0;
  logic [CNT_W-1:0] sector_count = '0;
  logic [15:0] bus_read_value = '0;
  logic [15:0] write_word = '0;
  logic intrq_level = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] bus_op;
  logic [2:0] bus_register;
  logic control_block;
  logic [15:0] bus_write_value;
  logic [15:0] read_data;
  logic read_data_valid;
  logic done_res;
  logic [2:0] outcome;
  logic [17:0] byte_count;
  logic last;

  ata_pio_sector_transfer_unit uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow config
  logic        s_use_lba = 1'b1;
  logic [7:0]  s_spt = 8'd63;
  logic [4:0]  s_heads = 5'd16;
  logic        s_slave = 1'b0;
  logic        s_irq_en = 1'b0;
  logic [19:0] s_rdy_to = 20'd500000;
  logic [19:0] s_drq_lim = 20'd100000;
  logic [19:0] s_rec_to = 20'd200000;

  // shadow sequencer state
  seq_ph_t     ph = PH_IDLE;
  logic        is_wr = 1'b0;
  logic [8:0]  sec_left = '0;
  logic [8:0]  sec_done = '0;
  int          word_idx = 0;
  longint      polls = 0;
  logic [27:0] cmd_lba = '0;
  logic [8:0]  cmd_cnt = '0;
  logic [2:0]  fail_code = OUT_OK;

  bus_beat_t step_q[$];
  bus_beat_t expected_q[$];

  int errors = 0;
  int accepted = 0;
  int results_seen = 0;
  int cmds_done = 0;
  int words_moved = 0;
  int idle_wait = 0;
  int snd_idle = 0;
  int rcv_stall = 0;
  int hold_req = 0;
  int force_cnt = 0;
  int cur_chk = 0;

  // ---------------- predictor ----------------
  task push_bus(input logic [2:0] op, input logic [2:0] r, input logic cb,
                input logic [15:0] v);
    bus_beat_t b;
    b = '{default: '0};
    b.op = op; b.rsel = r; b.cb = cb; b.wval = v;
    step_q.push_back(b);
  endtask

  function automatic logic [7:0] dev_sel();
    return s_slave ? DEV_SLAVE : DEV_MASTER;
  endfunction

  task end_cmd(input logic [2:0] oc);
    bus_beat_t b;
    b = '{default: '0};
    b.done = 1'b1; b.outc = oc;
    b.bytes = (oc == OUT_OK) ? 18'(cmd_cnt * 512) : 18'd0;
    step_q.push_back(b);
    ph = PH_IDLE;
    cmds_done++;
  endtask

  // status read request; an asserted INTRQ may steer through the clear phase
  task status_req(input seq_ph_t rp, input logic irq);
    logic clr;
    clr = (rp == PH_DRQ_RD && !(is_wr && sec_done == 0)) || rp == PH_CMT_RD;
    clr = clr && s_irq_en && irq;
    push_bus(OP_REG_RD, TF_CMDSTAT, 1'b0, 16'd0);
    ph = clr ? seq_ph_t'(rp - 1) : rp;
  endtask

  task after_srst();
    if (!s_use_lba) begin
      push_bus(OP_REG_WR, TF_DEVHEAD, 1'b0, 16'(dev_sel() | ((s_heads + 5'd15) & 5'h0F)));
      push_bus(OP_REG_WR, TF_NSECT, 1'b0, 16'(s_spt));
      push_bus(OP_REG_WR, TF_CMDSTAT, 1'b0, 16'(CMD_INIT_PARAMS));
      polls = 0;
      status_req(PH_GEO_RD, 1'b0);
    end else begin
      end_cmd(fail_code);
    end
  endtask

  task recover(input logic [2:0] code);
    fail_code = code;
    push_bus(OP_REG_WR, TF_DEVHEAD, 1'b1, 16'(DEVCTL_SRST));
    push_bus(OP_REG_WR, TF_DEVHEAD, 1'b1, 16'd0);
    polls = 0;
    status_req(PH_REC_RD, 1'b0);
  endtask

  task load_taskfile(input logic irq);
    longint spt, hd, trk, cyl, a;
    a = cmd_lba;
    push_bus(OP_REG_WR, TF_NSECT, 1'b0, 16'(cmd_cnt[7:0]));
    if (s_use_lba) begin
      push_bus(OP_REG_WR, TF_SECNUM, 1'b0, 16'(cmd_lba[7:0]));
      push_bus(OP_REG_WR, TF_CYLLO, 1'b0, 16'(cmd_lba[15:8]));
      push_bus(OP_REG_WR, TF_CYLHI, 1'b0, 16'(cmd_lba[23:16]));
      push_bus(OP_REG_WR, TF_DEVHEAD, 1'b0, 16'(dev_sel() | DEV_LBA | cmd_lba[27:24]));
    end else begin
      // zero geometry divides as one
      spt = (s_spt == 0) ? 1 : s_spt;
      hd = (s_heads == 0) ? 1 : s_heads;
      trk = a / spt;
      cyl = (trk / hd) & 16'hFFFF;
      push_bus(OP_REG_WR, TF_SECNUM, 1'b0, 16'(((a % spt) + 1) & 8'hFF));
      push_bus(OP_REG_WR, TF_CYLLO, 1'b0, 16'(cyl & 8'hFF));
      push_bus(OP_REG_WR, TF_CYLHI, 1'b0, 16'((cyl >> 8) & 8'hFF));
      push_bus(OP_REG_WR, TF_DEVHEAD, 1'b0, 16'(dev_sel() | ((trk % hd) & 4'hF)));
    end
    push_bus(OP_REG_WR, TF_CMDSTAT, 1'b0,
             16'(is_wr ? CMD_WRITE_SECTORS : CMD_READ_SECTORS));
    polls = 0;
    sec_done = 0;
    status_req(PH_DRQ_RD, irq);
  endtask

  task poll_miss(input seq_ph_t rp);
    longint lim;
    if (rp == PH_RDY_RD) lim = s_rdy_to;
    else if (rp == PH_DRQ_RD || rp == PH_CMT_RD) lim = s_drq_lim;
    else lim = s_rec_to;
    if (polls < PC_MAX) polls++;
    if (polls >= lim || polls == PC_MAX) begin
      if (rp == PH_RDY_RD) end_cmd(OUT_NOT_RDY);
      else if (rp == PH_REC_RD) after_srst();
      else if (rp == PH_GEO_RD) end_cmd(fail_code);
      else recover(OUT_TIMEOUT);
    end else begin
      ph = seq_ph_t'(rp + 1);
    end
  endtask

  task close_sector(input logic irq);
    sec_done = sec_done + 9'd1;
    sec_left = sec_left - 9'd1;
    polls = 0;
    if (sec_left != 0) status_req(PH_DRQ_RD, irq);
    else if (is_wr) status_req(PH_CMT_RD, irq);
    else end_cmd(OUT_OK);
  endtask

  task take_status(input logic [7:0] st, input logic irq);
    logic bsy, rdy;
    bsy = st[7];
    rdy = !bsy && st[6];
    case (ph)
      PH_RDY_RD: if (rdy) load_taskfile(irq); else poll_miss(PH_RDY_RD);
      PH_DRQ_RD: begin
        if (st[0]) recover(OUT_DEV_ERR);
        else if (!bsy && st[3]) begin
          word_idx = 0;
          if (is_wr) ph = PH_XFER_WR;
          else begin
            ph = PH_XFER_RD;
            push_bus(OP_DATA_RD, TF_DATA, 1'b0, 16'd0);
          end
        end else poll_miss(PH_DRQ_RD);
      end
      PH_CMT_RD: begin
        if (st[0]) recover(OUT_DEV_ERR);
        else if (!bsy) end_cmd(OUT_OK);
        else poll_miss(PH_CMT_RD);
      end
      PH_REC_RD: if (rdy) after_srst(); else poll_miss(PH_REC_RD);
      default: if (rdy) end_cmd(fail_code); else poll_miss(PH_GEO_RD);
    endcase
  endtask

  // advance the shadow sequencer by one input beat; results land in step_q
  task seq_predict(input logic [2:0] m, input logic [27:0] a, input logic [8:0] n,
                   input logic [15:0] rv, input logic [15:0] ww, input logic irq);
    bus_beat_t b;
    step_q.delete();
    if (m == MODE_START_RD || m == MODE_START_WR) begin
      if (ph == PH_IDLE) begin
        is_wr = (m == MODE_START_WR);
        cmd_lba = a;
        if (n == 0 || n > 256) begin
          cmd_cnt = 0;
          end_cmd(OUT_ZERO_CNT);
        end else begin
          cmd_cnt = n;
          sec_left = n;
          sec_done = 0;
          fail_code = OUT_OK;
          polls = 0;
          status_req(PH_RDY_RD, 1'b0);
        end
      end
    end else if (m == MODE_RESP) begin
      if (ph == PH_DRQ_CLR || ph == PH_CMT_CLR) begin
        push_bus(OP_REG_RD, TF_CMDSTAT, 1'b0, 16'd0);
        ph = seq_ph_t'(ph + 1);
      end else if (ph == PH_XFER_RD) begin
        b = '{default: '0};
        b.rdata = rv; b.rvalid = 1'b1;
        step_q.push_back(b);
        words_moved++;
        if (word_idx >= WORDS_PER_SECTOR - 1) close_sector(irq);
        else begin
          word_idx++;
          push_bus(OP_DATA_RD, TF_DATA, 1'b0, 16'd0);
        end
      end else if (ph inside {PH_RDY_RD, PH_DRQ_RD, PH_CMT_RD, PH_REC_RD, PH_GEO_RD}) begin
        take_status(rv[7:0], irq);
      end
    end else if (m == MODE_TICK) begin
      if (ph inside {PH_RDY_TK, PH_DRQ_TK, PH_CMT_TK, PH_REC_TK, PH_GEO_TK})
        status_req(seq_ph_t'(ph - 1), irq);
    end else if (m == MODE_WORD) begin
      if (ph == PH_XFER_WR) begin
        push_bus(OP_DATA_WR, TF_DATA, 1'b0, ww);
        words_moved++;
        if (word_idx >= WORDS_PER_SECTOR - 1) close_sector(irq);
        else word_idx++;
      end
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
  endtask

  // ---------------- checking ----------------
  task report(input string what);
    errors++;
    if (errors <= 20) $display("%0t: %s", $realtime, what);
  endtask

  task check_beat();
    bus_beat_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result beat op=%0d done=%0d", bus_op, done_res));
    end else begin
      e = expected_q.pop_front();
      if (bus_op !== e.op) report($sformatf("bus_op %0d, want %0d", bus_op, e.op));
      if (bus_register !== e.rsel)
        report($sformatf("bus_register %0d, want %0d", bus_register, e.rsel));
      if (control_block !== e.cb)
        report($sformatf("control_block %0d, want %0d", control_block, e.cb));
      if (bus_write_value !== e.wval)
        report($sformatf("bus_write_value %h, want %h", bus_write_value, e.wval));
      if (read_data !== e.rdata)
        report($sformatf("read_data %h, want %h", read_data, e.rdata));
      if (read_data_valid !== e.rvalid)
        report($sformatf("read_data_valid %0d, want %0d", read_data_valid, e.rvalid));
      if (done_res !== e.done) report($sformatf("done_res %0d, want %0d", done_res, e.done));
      if (outcome !== e.outc) report($sformatf("outcome %0d, want %0d", outcome, e.outc));
      if (byte_count !== e.bytes)
        report($sformatf("byte_count %0d, want %0d", byte_count, e.bytes));
      if (last !== e.last) report($sformatf("last %0d, want %0d", last, e.last));
    end
  endtask

  // sample both channels at the rising edge; watchdog on idle handshakes
  always @(posedge clk) begin
    bus_beat_t z;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seq_predict(mode, lba, sector_count, bus_read_value, write_word, intrq_level);
        if (cur_chk == 1) begin
          z = '{default: '0};
          z.done = 1'b1; z.outc = OUT_ZERO_CNT; z.last = 1'b1;
          step_q.delete();
          step_q.push_back(z);
        end else if (cur_chk == 2) begin
          step_q.delete();
        end
        foreach (step_q[i]) expected_q.push_back(step_q[i]);
        accepted++;
      end
      if (out_valid && out_ready) begin
        check_beat();
        results_seen++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_wait = 0;
      else idle_wait++;
      if (idle_wait >= WDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results still due",
                 idle_wait, expected_q.size());
        $display("ata_pio_sector_transfer_unit: mismatch");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    int hold_left;
    if (hold_req != 0) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (rst) out_ready = 1'b0;
    else if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else out_ready = ($urandom_range(99) >= rcv_stall);
  end

  // ---------------- stimulus ----------------
  task send_beat(input logic [2:0] m, input logic [27:0] a, input logic [8:0] n,
                 input logic [15:0] rv, input logic [15:0] ww, input logic irq,
                 input int chk);
    int seen;
    if (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    mode = m; lba = a; sector_count = n; bus_read_value = rv;
    write_word = ww; intrq_level = irq; cur_chk = chk;
    in_valid = 1'b1;
    seen = accepted;
    do @(negedge clk); while (accepted == seen);
  endtask

  // status byte for a wait: mostly satisfying, some busy, some error
  function automatic logic [15:0] pick_status();
    int r;
    logic [15:0] v;
    r = $urandom_range(99);
    v = 16'($urandom);
    if (r < 55) v = (v & ~16'h0081) | 16'h0048;
    else if (r < 85) v = (v & ~16'h0001) | 16'h0080;
    else v = v | 16'h0001;
    return v;
  endfunction

  // one beat shaped by what the sequencer waits for, with some noise
  task next_beat();
    logic [2:0] m;
    logic [8:0] n;
    logic [15:0] rv;
    int r;
    m = MODE_TICK;
    n = 9'($urandom);
    rv = 16'($urandom);
    if ($urandom_range(99) < 8) begin
      m = (ph == PH_IDLE) ? 3'($urandom_range(2, 7)) : 3'($urandom_range(0, 7));
    end else begin
      case (ph)
        PH_IDLE: begin
          m = $urandom_range(1) ? MODE_START_WR : MODE_START_RD;
          r = $urandom_range(99);
          if (force_cnt != 0) begin
            n = 9'(force_cnt);
            force_cnt = 0;
          end else if (r < 6) n = 0;
          else if (r < 12) n = 9'($urandom_range(257, 511));
          else if (r < 80) n = 1;
          else n = 9'($urandom_range(2, 3));
        end
        PH_RDY_RD, PH_DRQ_RD, PH_CMT_RD, PH_REC_RD, PH_GEO_RD: begin
          m = MODE_RESP;
          rv = pick_status();
        end
        PH_DRQ_CLR, PH_CMT_CLR, PH_XFER_RD: m = MODE_RESP;
        PH_XFER_WR: m = MODE_WORD;
        default: m = MODE_TICK;
      endcase
    end
    send_beat(m, 28'($urandom), n, rv, 16'($urandom), 1'($urandom), 0);
  endtask

  task run_cmds(input int cnt);
    int goal;
    goal = cmds_done + cnt;
    while (cmds_done < goal || ph != PH_IDLE) next_beat();
  endtask

  // drain all due results, then let any result-free decode settle
  task wait_drained();
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task cfg_write(input logic [2:0] idx, input logic [19:0] v);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_USE_LBA:  s_use_lba = v[0];
      REG_SPT:      s_spt = v[7:0];
      REG_HEADS:    s_heads = v[4:0];
      REG_SLAVE:    s_slave = v[0];
      REG_INTRQ_EN: s_irq_en = v[0];
      REG_RDY_TO:   s_rdy_to = v;
      REG_DRQ_LIM:  s_drq_lim = v;
      default:      s_rec_to = v;
    endcase
  endtask

  task set_geometry(input logic lba_mode, input logic [7:0] spt, input logic [4:0] hd,
                    input logic slv, input logic irq_en);
    cfg_write(REG_USE_LBA, 20'(lba_mode));
    cfg_write(REG_SPT, 20'(spt));
    cfg_write(REG_HEADS, 20'(hd));
    cfg_write(REG_SLAVE, 20'(slv));
    cfg_write(REG_INTRQ_EN, 20'(irq_en));
  endtask

  task set_limits(input logic [19:0] rdy, input logic [19:0] drq, input logic [19:0] rec);
    cfg_write(REG_RDY_TO, rdy);
    cfg_write(REG_DRQ_LIM, drq);
    cfg_write(REG_REC_TO, rec);
  endtask

  row_t rows[$];

  initial begin
    // idle-state rejects and ignores first, then one read walked through busy,
    // device error and recovery, then a write left at its data phase
    rows = '{
      '{MODE_START_RD, 28'h0, 9'd0, 16'h0, 16'h0, 1'b0, 1},
      '{MODE_START_WR, 28'hFFFFFFF, 9'd257, 16'h0, 16'h0, 1'b1, 1},
      '{MODE_START_RD, 28'hFFFFFFF, 9'd511, 16'hFFFF, 16'hFFFF, 1'b1, 1},
      '{MODE_RESP, 28'h0, 9'd1, 16'hFFFF, 16'h0, 1'b1, 2},
      '{MODE_TICK, 28'h0, 9'd1, 16'h0, 16'h0, 1'b0, 2},
      '{MODE_WORD, 28'h0, 9'd1, 16'h0, 16'hFFFF, 1'b0, 2},
      '{3'd5, 28'hFFFFFFF, 9'h1FF, 16'hFFFF, 16'hFFFF, 1'b1, 2},
      '{3'd6, 28'hFFFFFFF, 9'h1FF, 16'hFFFF, 16'hFFFF, 1'b1, 2},
      '{3'd7, 28'hFFFFFFF, 9'h1FF, 16'hFFFF, 16'hFFFF, 1'b1, 2},
      '{MODE_START_RD, 28'hFFFFFFF, 9'd1, 16'h0, 16'h0, 1'b0, 0},
      '{MODE_RESP, 28'h0, 9'd0, 16'h0080, 16'h0, 1'b0, 0},
      '{MODE_RESP, 28'h0, 9'd0, 16'h0050, 16'h0, 1'b0, 0},
      '{MODE_TICK, 28'h0, 9'd0, 16'h0, 16'h0, 1'b1, 0},
      '{MODE_RESP, 28'h0, 9'd0, 16'h0050, 16'h0, 1'b0, 0},
      '{MODE_RESP, 28'h0, 9'd0, 16'h0001, 16'h0, 1'b0, 0},
      '{MODE_RESP, 28'h0, 9'd0, 16'h0040, 16'h0, 1'b0, 0},
      '{MODE_START_WR, 28'h0, 9'd256, 16'h0, 16'h0, 1'b0, 0},
      '{MODE_START_WR, 28'h0, 9'd1, 16'h0, 16'h0, 1'b0, 0},
      '{MODE_RESP, 28'h0, 9'd0, 16'h0058, 16'h0, 1'b0, 0},
      '{MODE_RESP, 28'h0, 9'd0, 16'h0058, 16'h0, 1'b1, 0}
    };
    // row 17 starts a 256-sector write that must not be entered: keep count 1
    rows.delete(16);

    repeat (9) @(negedge clk);
    rst = 1'b0;

    // phase 0: reset defaults, no idling
    foreach (rows[i])
      send_beat(rows[i].m, rows[i].a, rows[i].n, rows[i].rv, rows[i].ww, rows[i].irq,
                rows[i].chk);
    run_cmds(8);
    wait_drained();

    // phase 1: CHS, widest track, slave, INTRQ clears, tight timeouts
    set_geometry(1'b0, 8'd255, 5'd16, 1'b1, 1'b1);
    set_limits(20'd1, 20'd3, 20'd2);
    snd_idle = 62; rcv_stall = 0;
    run_cmds(10);
    wait_drained();

    // phase 2: CHS one-sector tracks, one head, largest timeouts, receiver stalls
    set_geometry(1'b0, 8'd1, 5'd1, 1'b0, 1'b0);
    set_limits(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    snd_idle = 0; rcv_stall = 62;
    run_cmds(5);
    wait_drained(); // sender holds until every result is back
    run_cmds(5);
    wait_drained();

    // phase 3: zero geometry (divides as one), odd head field, both sides idle
    set_geometry(1'b0, 8'd0, 5'd0, 1'b1, 1'b1);
    set_limits(20'd1, 20'd1, 20'd1);
    snd_idle = 26; rcv_stall = 26;
    run_cmds(5);
    wait_drained();
    cfg_write(REG_HEADS, 20'd31);
    cfg_write(REG_SPT, 20'd17);
    run_cmds(5);
    wait_drained();

    // phase 4: LBA with INTRQ, long receiver hold-off, one full 256-sector read or write
    set_geometry(1'b1, 8'd63, 5'd16, 1'b0, 1'b1);
    set_limits(20'd4, 20'd4, 20'd4);
    snd_idle = 0; rcv_stall = 0;
    hold_req = 1;
    run_cmds(6);
    force_cnt = 256;
    run_cmds(1);
    run_cmds(4);

    in_valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("covered %0d input beats, %0d result beats, %0d commands, %0d data words",
             accepted, results_seen, cmds_done, words_moved);
    $display("LBA and CHS incl. zero geometry, slave/INTRQ, timeouts, errors, stalls");
    if (errors == 0) $display("ata_pio_sector_transfer_unit: match");
    else $display("ata_pio_sector_transfer_unit: mismatch");
    $finish;
  end

endmodule
